FILE: src/kfl_pkg.sv
package kfl_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned CoordW = 32;
  // Squared distance: three squares of 33-bit differences.
  localparam int unsigned DistW = 68;

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_PREPEND = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_REPLACE = 3'd4,
    REQ_CLOSE   = 3'd5,
    REQ_CLEAR   = 3'd6,
    REQ_READ    = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] eye_x;
    logic signed [CoordW-1:0] eye_y;
    logic signed [CoordW-1:0] eye_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic signed [CoordW-1:0] up_x;
    logic signed [CoordW-1:0] up_y;
    logic signed [CoordW-1:0] up_z;
  } key_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [IdxW-1:0] entry_index;
    key_t            key;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [CntW-1:0] entry_count;
    logic [IdxW-1:0] touched_index;
    key_t            key;
  } rsp_t;

  // Control to every cell in the row.
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_SHR   = 3'd1,
    CELL_SHL   = 3'd2,
    CELL_WRITE = 3'd3,
    CELL_ROTL  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    key_t            wr;
  } cell_ctl_t;

endpackage

FILE: src/kfl_cell.sv
module kfl_cell (
  input  logic              clk_i,
  input  kfl_pkg::cell_ctl_t ctl_i,
  input  logic [kfl_pkg::IdxW-1:0] my_idx_i,
  input  kfl_pkg::key_t     left_i,
  input  kfl_pkg::key_t     right_i,
  output kfl_pkg::key_t     key_o
);
  import kfl_pkg::*;

  key_t key_q, key_d;
  logic in_rng;

  assign in_rng = (my_idx_i >= ctl_i.lo) && (my_idx_i <= ctl_i.hi);

  // Shift right takes the left neighbor; shift left and rotate take the right one.
  // The top cell of a rotation wraps around to the head entry carried on wr.
  always_comb begin
    key_d = key_q;
    if (in_rng) begin
      case (ctl_i.op)
        CELL_SHR:   key_d = (my_idx_i == ctl_i.lo) ? ctl_i.wr : left_i;
        CELL_SHL:   key_d = right_i;
        CELL_ROTL:  key_d = (my_idx_i == ctl_i.hi) ? ctl_i.wr : right_i;
        CELL_WRITE: key_d = ctl_i.wr;
        default:    key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
endmodule

FILE: src/kfl_dist.sv
module kfl_dist (
  input  logic                      clk_i,
  input  logic signed [kfl_pkg::CoordW-1:0] a_i,
  input  logic signed [kfl_pkg::CoordW-1:0] b_i,
  output logic [kfl_pkg::DistW-1:0] sq_o
);
  import kfl_pkg::*;

  logic signed [CoordW:0] d;
  logic [CoordW:0] m;
  logic [2*CoordW+1:0] sq_q;

  assign d = {a_i[CoordW-1], a_i} - {b_i[CoordW-1], b_i};
  assign m = d[CoordW] ? (~d + 1'b1) : d;

  always_ff @(posedge clk_i) begin
    sq_q <= m * m;
  end

  assign sq_o = DistW'(sq_q);
endmodule

FILE: src/keyframe_list_nearest_edit.sv
// Channel | direction | handshake               | payload
// req     | in        | req_valid_i/req_stall_o | kfl_pkg::req_t
// rsp     | out       | rsp_valid_o/rsp_stall_i | kfl_pkg::rsp_t
// One item at a time. The nearest search rotates the row once so that cell 0
// holds each entry in turn; an insert next to an inner entry also measures
// both neighbors. The edit then shifts or writes the row. Reset clears the
// count and control; entries are not cleared. A stalled result is held in
// the output register.
module keyframe_list_nearest_edit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  kfl_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output kfl_pkg::rsp_t rsp_o
);
  import kfl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_NBR  = 6'b000100,
    S_NBR2 = 6'b001000,
    S_EXEC = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  req_t req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  cell_ctl_t ctl;
  key_t keys [Depth];
  rsp_t rsp_q, rsp_d;
  logic rsp_v_q;

  logic [CntW-1:0] step_q;   // rotations done / pipeline counter
  logic [IdxW-1:0] best_q;
  logic [DistW-1:0] bd_q, prev_q;
  logic best_ok_q;
  logic [IdxW-1:0] pos_q;

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_row
      kfl_cell u_cell (
        .clk_i,
        .ctl_i   (ctl),
        .my_idx_i(IdxW'(g)),
        .left_i  (keys[(g + Depth - 1) % Depth]),
        .right_i (keys[(g + 1) % Depth]),
        .key_o   (keys[g])
      );
    end
  endgenerate

  // Distance of the entry now at cell 0 (rotation head) or a neighbor.
  logic [IdxW-1:0] probe_idx;
  key_t probe;
  logic [DistW-1:0] sx, sy, sz, gap_sum;
  assign probe = keys[probe_idx];
  kfl_dist u_dx (.clk_i, .a_i(req_q.key.eye_x), .b_i(probe.eye_x), .sq_o(sx));
  kfl_dist u_dy (.clk_i, .a_i(req_q.key.eye_y), .b_i(probe.eye_y), .sq_o(sy));
  kfl_dist u_dz (.clk_i, .a_i(req_q.key.eye_z), .b_i(probe.eye_z), .sq_o(sz));
  assign gap_sum = sx + sy + sz;

  logic [CntW-1:0] last;
  assign last = cnt_q - 1'b1;
  // Rotation over entries 0..count-1: cell 0 always holds the next entry.
  always_comb begin
    probe_idx = '0;
    if (state_q == S_NBR) probe_idx = best_q - 1'b1;
    else if (state_q == S_NBR2) probe_idx = best_q + 1'b1;
  end

  logic needs_scan;
  always_comb begin
    needs_scan = 1'b0;
    case (req_i.req_type)
      REQ_INSERT:              needs_scan = (cnt_q > CntW'(2)) && (cnt_q < CntW'(Depth));
      REQ_REMOVE, REQ_REPLACE: needs_scan = (cnt_q != '0);
      default:                 needs_scan = 1'b0;
    endcase
  end

  logic scan_rot, scan_done, scan_upd;
  logic [IdxW-1:0] best_nx;
  // step_q counts cycles; distances arrive in the cycle after the probe.
  assign scan_rot  = (state_q == S_SCAN) && (step_q < cnt_q);
  assign scan_done = (state_q == S_SCAN) && (step_q == cnt_q);
  assign scan_upd  = (state_q == S_SCAN) && (step_q != '0) &&
                     (!best_ok_q || gap_sum < bd_q);
  assign best_nx   = scan_upd ? IdxW'(step_q - 1'b1) : best_q;

  always_comb begin
    ctl = '{op: CELL_HOLD, lo: '0, hi: '0, wr: req_q.key};
    state_d = state_q;
    cnt_d = cnt_q;
    rsp_d = rsp_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) state_d = needs_scan ? S_SCAN : S_EXEC;
      S_SCAN: begin
        if (scan_rot) begin
          ctl.op = CELL_ROTL;
          ctl.hi = IdxW'(last);
          ctl.wr = keys[0];
        end
        if (scan_done) begin
          if (req_q.req_type == REQ_INSERT && best_nx != '0 &&
              CntW'(best_nx) != last) state_d = S_NBR;
          else state_d = S_EXEC;
        end
      end
      S_NBR:  state_d = S_NBR2;
      S_NBR2: if (step_q == CntW'(2)) state_d = S_EXEC;
      S_EXEC: begin
        rsp_d = '0;
        rsp_d.status = ST_DONE;
        unique case (req_q.req_type)
          REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
            if (cnt_q >= CntW'(Depth)) rsp_d.status = ST_FULL;
            else begin
              ctl.op = CELL_SHR;
              ctl.lo = pos_q;
              ctl.hi = IdxW'(cnt_q);
              cnt_d = cnt_q + 1'b1;
              rsp_d.touched_index = pos_q;
            end
          end
          REQ_REMOVE: begin
            if (cnt_q == '0) rsp_d.status = ST_NONE;
            else begin
              ctl.op = CELL_SHL;
              ctl.lo = best_q;
              ctl.hi = IdxW'(last);
              cnt_d = last;
              rsp_d.touched_index = best_q;
            end
          end
          REQ_REPLACE: begin
            if (cnt_q == '0) rsp_d.status = ST_NONE;
            else begin
              ctl.op = CELL_WRITE;
              ctl.lo = best_q;
              ctl.hi = best_q;
              rsp_d.touched_index = best_q;
            end
          end
          REQ_CLOSE: begin
            if (cnt_q < CntW'(2)) rsp_d.status = ST_NONE;
            else if (cnt_q >= CntW'(Depth)) rsp_d.status = ST_FULL;
            else begin
              ctl.op = CELL_WRITE;
              ctl.lo = IdxW'(cnt_q);
              ctl.hi = IdxW'(cnt_q);
              ctl.wr = keys[0];
              cnt_d = cnt_q + 1'b1;
              rsp_d.touched_index = IdxW'(cnt_q);
            end
          end
          REQ_CLEAR: cnt_d = '0;
          default: begin
            if (CntW'(req_q.entry_index) >= cnt_q) rsp_d.status = ST_RANGE;
            else begin
              rsp_d.touched_index = req_q.entry_index;
              rsp_d.key = keys[req_q.entry_index];
            end
          end
        endcase
        rsp_d.entry_count = cnt_d;
        state_d = S_OUT;
      end
      S_OUT: if (!rsp_v_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Position chosen for inserts that do not need the neighbor test.
  logic [IdxW-1:0] pos_early;
  always_comb begin
    unique case (req_i.req_type)
      REQ_APPEND: pos_early = IdxW'(cnt_q);
      REQ_INSERT: pos_early = (cnt_q < CntW'(2)) ? IdxW'(cnt_q) : IdxW'(1);
      default:    pos_early = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (state_q == S_EXEC) rsp_v_q <= 1'b1;
      else if (!rsp_stall_i) rsp_v_q <= 1'b0;
    end
  end

  // Scan datapath: the squares are registered, so the distance seen at step s
  // belongs to the entry probed at step s-1.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == S_IDLE) begin
      req_q <= req_i;
      step_q <= '0;
      best_q <= '0;
      best_ok_q <= 1'b0;
      pos_q <= pos_early;
    end else if (state_q == S_SCAN) begin
      step_q <= scan_done ? '0 : step_q + 1'b1;
      if (scan_upd) begin
        bd_q <= gap_sum;
        best_q <= best_nx;
        best_ok_q <= 1'b1;
      end
      // A nearest entry at either end fixes the slot; otherwise the neighbor test does.
      if (scan_done && req_q.req_type == REQ_INSERT)
        pos_q <= (best_nx == '0) ? IdxW'(1) : IdxW'(last);
    end else if (state_q == S_NBR || state_q == S_NBR2) begin
      step_q <= step_q + 1'b1;
      if (step_q == CntW'(1)) prev_q <= gap_sum;
      if (step_q == CntW'(2)) pos_q <= (prev_q < gap_sum) ? best_q : best_q + 1'b1;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("entry count above depth");

  property p_one_busy;
    @(posedge clk_i) disable iff (!rst_ni) rsp_v_q |-> state_q != S_EXEC;
  endproperty
  a_one_busy: assert property (p_one_busy) else $error("result overwritten");

  property p_cnt_step;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != S_EXEC) |=> $stable(cnt_q);
  endproperty
  a_cnt_step: assert property (p_cnt_step) else $error("count changed outside execute");
endmodule

FILE: sim/keyframe_list_nearest_edit_test.sv
module keyframe_list_nearest_edit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kfl_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  keyframe_list_nearest_edit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the keyframe list.
  key_t        frames [Depth];
  int unsigned frame_count;
  rsp_t        pending_rsp [$];
  int unsigned fail_count;
  int unsigned idle_cycles = 0;
  bit          stim_done;

  function automatic logic [DistW-1:0] sq_mag(logic signed [CoordW:0] d);
    logic [CoordW:0] m;
    m = d[CoordW] ? -d : d;
    return DistW'(m) * DistW'(m);
  endfunction

  function automatic logic [DistW-1:0] eye_gap2(key_t a, key_t b);
    return sq_mag({a.eye_x[CoordW-1], a.eye_x} - {b.eye_x[CoordW-1], b.eye_x})
         + sq_mag({a.eye_y[CoordW-1], a.eye_y} - {b.eye_y[CoordW-1], b.eye_y})
         + sq_mag({a.eye_z[CoordW-1], a.eye_z} - {b.eye_z[CoordW-1], b.eye_z});
  endfunction

  function automatic int unsigned nearest_frame(key_t k);
    int unsigned best;
    logic [DistW-1:0] best_d, d;
    best = 0;
    best_d = '0;
    for (int unsigned i = 0; i < frame_count; i++) begin
      d = eye_gap2(k, frames[i]);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic int unsigned insert_slot(key_t k);
    int unsigned nr;
    if (frame_count < 2) return frame_count;
    if (frame_count == 2) return 1;
    nr = nearest_frame(k);
    if (nr == 0) return 1;
    if (nr == frame_count - 1) return frame_count - 1;
    return (eye_gap2(k, frames[nr-1]) < eye_gap2(k, frames[nr+1])) ? nr : nr + 1;
  endfunction

  function automatic void place_frame(int unsigned pos, key_t k);
    for (int i = int'(frame_count); i > int'(pos); i--) frames[i] = frames[i-1];
    frames[pos] = k;
    frame_count++;
  endfunction

  function automatic rsp_t apply_edit(req_t r);
    rsp_t o;
    int unsigned pos;
    key_t first;
    o = '0;
    o.status = ST_DONE;
    case (req_e'(r.req_type))
      REQ_APPEND, REQ_PREPEND, REQ_INSERT: begin
        if (frame_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          pos = (r.req_type == REQ_APPEND) ? frame_count :
                (r.req_type == REQ_PREPEND) ? 0 : insert_slot(r.key);
          place_frame(pos, r.key);
          o.touched_index = IdxW'(pos);
        end
      end
      REQ_REMOVE, REQ_REPLACE: begin
        if (frame_count == 0) begin
          o.status = ST_NONE;
        end else begin
          pos = nearest_frame(r.key);
          if (r.req_type == REQ_REMOVE) begin
            for (int unsigned i = pos; i + 1 < frame_count; i++) frames[i] = frames[i+1];
            frame_count--;
          end else begin
            frames[pos] = r.key;
          end
          o.touched_index = IdxW'(pos);
        end
      end
      REQ_CLOSE: begin
        if (frame_count < 2) begin
          o.status = ST_NONE;
        end else if (frame_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          first = frames[0];
          o.touched_index = IdxW'(frame_count);
          place_frame(frame_count, first);
        end
      end
      REQ_CLEAR: frame_count = 0;
      default: begin
        if (r.entry_index >= frame_count) begin
          o.status = ST_RANGE;
        end else begin
          o.touched_index = r.entry_index;
          o.key = frames[r.entry_index];
        end
      end
    endcase
    o.entry_count = CntW'(frame_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [287:0] got, logic [287:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  function automatic logic [31:0] rand_coord(bit cluster);
    int unsigned p;
    p = $urandom_range(0, 9);
    if (cluster) return 32'($signed($urandom_range(0, 15)) - 8);
    if (p == 0) return 32'h8000_0000;
    if (p == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  function automatic req_t rand_req(int unsigned mode);
    req_t r;
    int unsigned p;
    bit cl;
    r = '0;
    p = $urandom_range(0, 99);
    // Insert-heavy phases fill the table; removal-heavy phases drain it.
    if (mode == 0)
      r.req_type = (p < 30) ? REQ_APPEND : (p < 45) ? REQ_PREPEND : (p < 75) ? REQ_INSERT :
                   (p < 80) ? REQ_REMOVE : (p < 85) ? REQ_REPLACE : (p < 90) ? REQ_CLOSE :
                   REQ_READ;
    else
      r.req_type = (p < 30) ? REQ_REMOVE : (p < 45) ? REQ_REPLACE : (p < 55) ? REQ_INSERT :
                   (p < 58) ? REQ_CLEAR : (p < 62) ? REQ_CLOSE : REQ_READ;
    r.entry_index = (p % 3 == 0) ? 6'($urandom) : 6'($urandom_range(0, frame_count));
    cl = 1'($urandom_range(0, 1));
    r.key.eye_x = rand_coord(cl);
    r.key.eye_y = rand_coord(cl);
    r.key.eye_z = rand_coord(cl);
    r.key.center_x = $urandom;
    r.key.center_y = $urandom;
    r.key.center_z = $urandom;
    r.key.up_x = $urandom;
    r.key.up_y = $urandom;
    r.key.up_z = $urandom;
    return r;
  endfunction

  // Valid drops only when a gap follows; the payload changes at the falling edge.
  task automatic send_req(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = apply_edit(r);
    if (typed && pred !== want)
      report_mismatch("typed row",
                      288'({pred.status, pred.entry_count, pred.touched_index}),
                      288'({want.status, want.entry_count, want.touched_index}));
    pending_rsp.push_back(pred);
    @(negedge clk);
  endtask

  // Directed rows: op, index, eye fill, check-typed, expected status/count/index.
  typedef struct {
    req_e        op;
    logic [5:0]  idx;
    logic [31:0] eye;
    bit          typed;
    status_e     st;
    int unsigned cnt;
    int unsigned tch;
  } row_t;

  row_t rows [] = '{
    '{REQ_READ,    6'd0,  32'h0,         1, ST_RANGE, 0, 0},
    '{REQ_REMOVE,  6'd0,  32'h0,         1, ST_NONE,  0, 0},
    '{REQ_REPLACE, 6'd0,  32'h0,         1, ST_NONE,  0, 0},
    '{REQ_CLOSE,   6'd0,  32'h0,         1, ST_NONE,  0, 0},
    '{REQ_INSERT,  6'd0,  32'h8000_0000, 1, ST_DONE,  1, 0},
    '{REQ_CLOSE,   6'd0,  32'h0,         1, ST_NONE,  1, 0},
    '{REQ_APPEND,  6'd0,  32'h7fff_ffff, 1, ST_DONE,  2, 1},
    '{REQ_INSERT,  6'd0,  32'h0,         1, ST_DONE,  3, 1},
    '{REQ_PREPEND, 6'd0,  32'h0000_0010, 1, ST_DONE,  4, 0},
    '{REQ_INSERT,  6'd0,  32'h8000_0001, 0, ST_DONE,  0, 0},
    '{REQ_INSERT,  6'd0,  32'h7fff_fff0, 0, ST_DONE,  0, 0},
    '{REQ_INSERT,  6'd0,  32'h0000_0008, 0, ST_DONE,  0, 0},
    '{REQ_INSERT,  6'd0,  32'h0000_0004, 0, ST_DONE,  0, 0},
    '{REQ_READ,    6'd63, 32'h0,         1, ST_RANGE, 8, 0},
    '{REQ_READ,    6'd0,  32'h0,         0, ST_DONE,  0, 0},
    '{REQ_READ,    6'd7,  32'h0,         0, ST_DONE,  0, 0},
    '{REQ_REPLACE, 6'd0,  32'h7fff_ffff, 0, ST_DONE,  0, 0},
    '{REQ_REMOVE,  6'd0,  32'h8000_0000, 0, ST_DONE,  0, 0},
    '{REQ_CLOSE,   6'd0,  32'h0,         1, ST_DONE,  8, 7},
    '{REQ_CLEAR,   6'd0,  32'h0,         1, ST_DONE,  0, 0},
    '{REQ_READ,    6'd0,  32'h0,         1, ST_RANGE, 0, 0}
  };

  initial begin
    req_t  r;
    rsp_t  w;
    int    sent;
    stim_done = 1'b0;
    frame_count = 0;
    fail_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      r = '0;
      r.req_type = rows[i].op;
      r.entry_index = rows[i].idx;
      r.key = {9{rows[i].eye}};
      r.key.center_y = ~rows[i].eye;
      r.key.up_z = 32'($urandom);
      w = '0;
      w.status = rows[i].st;
      w.entry_count = CntW'(rows[i].cnt);
      w.touched_index = IdxW'(rows[i].tch);
      send_req(r, rows[i].typed, w);
    end
    // Fill to full and exercise the full-table refusals.
    while (frame_count < Depth) send_req(rand_req(0), 0, '0);
    for (int k = REQ_APPEND; k <= REQ_CLOSE; k++) begin
      r = rand_req(0);
      r.req_type = 3'(k);
      if (k == REQ_APPEND || k == REQ_PREPEND || k == REQ_INSERT || k == REQ_CLOSE)
        send_req(r, 0, '0);
    end
    r = rand_req(0);
    r.req_type = REQ_READ;
    r.entry_index = 6'd63;
    send_req(r, 0, '0);
    sent = 0;
    while (sent < 950) begin
      int unsigned phase_len;
      int unsigned mode;
      mode = $urandom_range(0, 1);
      phase_len = $urandom_range(20, 150);
      for (int unsigned j = 0; j < phase_len && sent < 950; j++) begin
        send_req(rand_req(mode), 0, '0);
        sent++;
      end
    end
    req_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Response side: random stall, compare against the oldest prediction.
  initial begin
    int unsigned g;
    forever begin
      @(negedge clk);
      if (g == 0) begin
        rsp_stall <= 1'b0;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
      end else begin
        rsp_stall <= 1'b1;
        g--;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", 288'(rsp), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 288'(rsp.status), 288'(want.status));
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 288'(rsp.entry_count), 288'(want.entry_count));
        if (rsp.touched_index !== want.touched_index)
          report_mismatch("touched_index", 288'(rsp.touched_index), 288'(want.touched_index));
        if (rsp.key !== want.key)
          report_mismatch("key", 288'(rsp.key), 288'(want.key));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0 && idle_cycles < IdleLimit) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      repeat (250) @(posedge clk);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/kfl_pkg.sv
src/kfl_cell.sv
src/kfl_dist.sv
src/keyframe_list_nearest_edit.sv
sim/keyframe_list_nearest_edit_test.sv
